[hdl/segment_polygon_crossing_test_defines.svh]
// assertion macros used by the checker file
// each macro names the assertion, sits on the clk edge and is off during reset
`ifndef SEGMENT_POLYGON_CROSSING_TEST_DEFINES_SVH
`define SEGMENT_POLYGON_CROSSING_TEST_DEFINES_SVH

// same-cycle implication
`define SPCT_ASSERT_NOW(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("spct assertion failed");

// next-cycle implication
`define SPCT_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("spct assertion failed");

`endif

[hdl/spct_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spct_pkg
// Widths, types and codes of the segment versus polygon crossing test.
// ----------------------------------------------------------------------------
package spct_pkg;

    // coordinate width and the widths that follow from it
    localparam int COORD_BITS = 14;
    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int PROD_W     = 2 * DIFF_W;
    localparam int ACC_W      = PROD_W + 1;

    // configuration register file
    localparam int CFG_REGS  = 4;
    localparam int CFG_IDX_W = $clog2(CFG_REGS);

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]     diff_t;
    typedef logic signed [PROD_W-1:0]     prod_t;
    typedef logic signed [ACC_W-1:0]      acc_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_X,
        CFG_START_Y,
        CFG_END_X,
        CFG_END_Y
    } cfg_reg_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EDGE,
        ST_MUL,
        ST_CHECK,
        ST_OUT
    } state_t;

    // steps of the shared multiplier, one product each
    typedef enum logic [1:0] {
        STEP_DEN_P,
        STEP_DEN_Q,
        STEP_NUM_P,
        STEP_NUM_Q
    } mul_step_t;

    // exact difference of two coordinates
    function automatic diff_t sub_coord(input coord_t a, input coord_t b);
        return DIFF_W'(a) - DIFF_W'(b);
    endfunction

endpackage

[hdl/segment_polygon_crossing_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_polygon_crossing_test
// Tests a configured query segment against a streamed polygon ring.
// ----------------------------------------------------------------------------
// Usage:
// - the segment ends are written through the cfg port (cfg_valid/cfg_ready,
//   cfg_index selects start x, start y, end x, end y); cfg_ready is always high
// - vertices arrive on the input channel (in_valid/in_stall) in ring order,
//   last_vertex marks the beat that closes the ring back to the first vertex
// - one beat of crosses leaves on the output channel (out_valid/out_stall)
//   for each ring, on its last vertex; other vertices give no result
// - every edge runs through one 15x15 signed multiplier: a bounding box test,
//   four products, one compare; an edge that the box test rejects ends after
//   the box test and takes no products
// - the first vertex opens the ring and runs no edge; the last vertex runs its
//   own edge and then the closing edge (a one-point ring only the closing edge),
//   and then the result goes to the output register
// - in_stall is high while an item is at work
// - a stalled result holds in the output register; the next ring may enter,
//   but its own result waits until the register is free
// - reset clears the segment to zero, the ring state and the output valid
module segment_polygon_crossing_test (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // configuration
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [spct_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [spct_pkg::COORD_BITS-1:0]        cfg_data,
    // vertex input
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic signed [spct_pkg::COORD_BITS-1:0] vertex_x,
    input  logic signed [spct_pkg::COORD_BITS-1:0] vertex_y,
    input  logic                                   last_vertex,
    // result output
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic                                   crosses
);

    // configuration registers
    spct_pkg::coord_t seg_sx_reg, seg_sy_reg, seg_ex_reg, seg_ey_reg;

    // control
    spct_pkg::state_t    state_reg, state_next;
    spct_pkg::mul_step_t step_reg, step_next;
    logic                phase_reg, phase_next;
    logic                started_reg, started_next;
    logic                hit_reg, hit_next;
    logic                out_valid_reg, out_valid_next;

    // payload
    spct_pkg::coord_t first_x_reg, first_x_next, first_y_reg, first_y_next;
    spct_pkg::coord_t prev_x_reg, prev_x_next, prev_y_reg, prev_y_next;
    spct_pkg::coord_t cur_x_reg, cur_x_next, cur_y_reg, cur_y_next;
    logic             last_reg, last_next;
    spct_pkg::coord_t ax_reg, ax_next, ay_reg, ay_next;
    spct_pkg::coord_t bx_reg, bx_next, by_reg, by_next;
    spct_pkg::acc_t   den_reg, den_next, num_reg, num_next;
    logic             crosses_reg, crosses_next;

    // datapath
    spct_pkg::coord_t min_x, max_x, min_y, max_y;
    logic             box_reject;
    spct_pkg::diff_t  mul_a, mul_b;
    spct_pkg::prod_t  prod;
    logic             num_pos, num_neg, den_pos, den_nz, edge_hit;
    logic             edge_done;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != spct_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;
    assign crosses   = crosses_reg;

    // segment bounding box and the quick reject of the current edge
    always_comb
    begin
        min_x = (seg_sx_reg < seg_ex_reg) ? seg_sx_reg : seg_ex_reg;
        max_x = (seg_sx_reg < seg_ex_reg) ? seg_ex_reg : seg_sx_reg;
        min_y = (seg_sy_reg < seg_ey_reg) ? seg_sy_reg : seg_ey_reg;
        max_y = (seg_sy_reg < seg_ey_reg) ? seg_ey_reg : seg_sy_reg;
        box_reject = (ax_reg <= min_x && bx_reg <= min_x)
                  || (ax_reg >= max_x && bx_reg >= max_x)
                  || (ay_reg <= min_y && by_reg <= min_y)
                  || (ay_reg >= max_y && by_reg >= max_y);
    end

    // operand select for the shared multiplier
    always_comb
    begin
        case (step_reg)
            spct_pkg::STEP_DEN_P:
            begin
                mul_a = spct_pkg::sub_coord(seg_ex_reg, seg_sx_reg);
                mul_b = spct_pkg::sub_coord(by_reg, ay_reg);
            end
            spct_pkg::STEP_DEN_Q:
            begin
                mul_a = spct_pkg::sub_coord(seg_ey_reg, seg_sy_reg);
                mul_b = spct_pkg::sub_coord(bx_reg, ax_reg);
            end
            spct_pkg::STEP_NUM_P:
            begin
                mul_a = spct_pkg::sub_coord(ax_reg, seg_sx_reg);
                mul_b = spct_pkg::sub_coord(by_reg, ay_reg);
            end
            spct_pkg::STEP_NUM_Q:
            begin
                mul_a = spct_pkg::sub_coord(ay_reg, seg_sy_reg);
                mul_b = spct_pkg::sub_coord(bx_reg, ax_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod = mul_a * mul_b;
    end

    // strict 0 < num/den < 1 with the sign of den folded in
    always_comb
    begin
        num_neg  = num_reg[spct_pkg::ACC_W-1];
        num_pos  = !num_neg && (num_reg != '0);
        den_pos  = !den_reg[spct_pkg::ACC_W-1];
        den_nz   = (den_reg != '0);
        edge_hit = den_nz && (den_pos ? (num_pos && num_reg < den_reg)
                                      : (num_neg && num_reg > den_reg));
    end

    // sequencer: next state and datapath controls
    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        phase_next     = phase_reg;
        started_next   = started_reg;
        hit_next       = hit_reg;
        out_valid_next = out_valid_reg && out_stall;
        first_x_next   = first_x_reg;
        first_y_next   = first_y_reg;
        prev_x_next    = prev_x_reg;
        prev_y_next    = prev_y_reg;
        cur_x_next     = cur_x_reg;
        cur_y_next     = cur_y_reg;
        last_next      = last_reg;
        ax_next        = ax_reg;
        ay_next        = ay_reg;
        bx_next        = bx_reg;
        by_next        = by_reg;
        den_next       = den_reg;
        num_next       = num_reg;
        crosses_next   = crosses_reg;
        edge_done      = 1'b0;

        case (state_reg)
            spct_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    cur_x_next  = vertex_x;
                    cur_y_next  = vertex_y;
                    last_next   = last_vertex;
                    prev_x_next = vertex_x;
                    prev_y_next = vertex_y;
                    if (started_reg)
                    begin
                        // edge from the previous vertex
                        ax_next    = prev_x_reg;
                        ay_next    = prev_y_reg;
                        bx_next    = vertex_x;
                        by_next    = vertex_y;
                        phase_next = 1'b0;
                        state_next = spct_pkg::ST_EDGE;
                    end
                    else
                    begin
                        first_x_next = vertex_x;
                        first_y_next = vertex_y;
                        started_next = 1'b1;
                        if (last_vertex)
                        begin
                            // one-point ring: degenerate closing edge
                            ax_next    = vertex_x;
                            ay_next    = vertex_y;
                            bx_next    = vertex_x;
                            by_next    = vertex_y;
                            phase_next = 1'b1;
                            state_next = spct_pkg::ST_EDGE;
                        end
                    end
                end
            end
            spct_pkg::ST_EDGE:
            begin
                if (box_reject)
                begin
                    edge_done = 1'b1;
                end
                else
                begin
                    den_next   = '0;
                    num_next   = '0;
                    step_next  = spct_pkg::STEP_DEN_P;
                    state_next = spct_pkg::ST_MUL;
                end
            end
            spct_pkg::ST_MUL:
            begin
                case (step_reg)
                    spct_pkg::STEP_DEN_P: den_next = den_reg + spct_pkg::ACC_W'(prod);
                    spct_pkg::STEP_DEN_Q: den_next = den_reg - spct_pkg::ACC_W'(prod);
                    spct_pkg::STEP_NUM_P: num_next = num_reg + spct_pkg::ACC_W'(prod);
                    spct_pkg::STEP_NUM_Q: num_next = num_reg - spct_pkg::ACC_W'(prod);
                    default:              den_next = den_reg;
                endcase
                if (step_reg == spct_pkg::STEP_NUM_Q)
                begin
                    state_next = spct_pkg::ST_CHECK;
                end
                else
                begin
                    step_next = spct_pkg::mul_step_t'(step_reg + 2'd1);
                end
            end
            spct_pkg::ST_CHECK:
            begin
                if (edge_hit)
                begin
                    hit_next = 1'b1;
                end
                edge_done = 1'b1;
            end
            spct_pkg::ST_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    crosses_next   = hit_reg;
                    hit_next       = 1'b0;
                    started_next   = 1'b0;
                    state_next     = spct_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = spct_pkg::ST_IDLE;
            end
        endcase

        // route to the closing edge, the result or back to idle
        if (edge_done)
        begin
            if (!phase_reg && last_reg)
            begin
                ax_next    = cur_x_reg;
                ay_next    = cur_y_reg;
                bx_next    = first_x_reg;
                by_next    = first_y_reg;
                phase_next = 1'b1;
                state_next = spct_pkg::ST_EDGE;
            end
            else if (last_reg)
            begin
                state_next = spct_pkg::ST_OUT;
            end
            else
            begin
                state_next = spct_pkg::ST_IDLE;
            end
        end
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_sx_reg <= '0;
            seg_sy_reg <= '0;
            seg_ex_reg <= '0;
            seg_ey_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (spct_pkg::cfg_reg_t'(cfg_index))
                spct_pkg::CFG_START_X: seg_sx_reg <= cfg_data;
                spct_pkg::CFG_START_Y: seg_sy_reg <= cfg_data;
                spct_pkg::CFG_END_X:   seg_ex_reg <= cfg_data;
                spct_pkg::CFG_END_Y:   seg_ey_reg <= cfg_data;
                default:               seg_sx_reg <= seg_sx_reg;
            endcase
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= spct_pkg::ST_IDLE;
            step_reg      <= spct_pkg::STEP_DEN_P;
            phase_reg     <= 1'b0;
            started_reg   <= 1'b0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            phase_reg     <= phase_next;
            started_reg   <= started_next;
            hit_reg       <= hit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        first_x_reg <= first_x_next;
        first_y_reg <= first_y_next;
        prev_x_reg  <= prev_x_next;
        prev_y_reg  <= prev_y_next;
        cur_x_reg   <= cur_x_next;
        cur_y_reg   <= cur_y_next;
        last_reg    <= last_next;
        ax_reg      <= ax_next;
        ay_reg      <= ay_next;
        bx_reg      <= bx_next;
        by_reg      <= by_next;
        den_reg     <= den_next;
        num_reg     <= num_next;
        crosses_reg <= crosses_next;
    end

endmodule

[hdl/spct_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spct_checker
// Port-level checks of the segment versus polygon crossing test.
// ----------------------------------------------------------------------------
`include "segment_polygon_crossing_test_defines.svh"

module spct_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_stall,
    input logic last_vertex,
    input logic out_valid,
    input logic out_stall,
    input logic crosses
);

    // a stalled result beat holds its value
    `SPCT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(crosses))

    // a last vertex always starts edge work, so the input stalls next
    `SPCT_ASSERT_NEXT(a_last_busy, in_valid && !in_stall && last_vertex, in_stall)

    // a new result appears only out of a busy cycle
    `SPCT_ASSERT_NOW(a_out_from_busy, $rose(out_valid), $past(in_stall))

endmodule

bind segment_polygon_crossing_test spct_checker u_spct_checker (.*);

[sim/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the segment versus polygon crossing test. Polygon
// rings are streamed vertex by vertex against a range of query segments. A
// bit-exact predictor of the ring state gives the expected crosses flag, and
// the flag is checked on every output beat.
// ----------------------------------------------------------------------------
module tb;

    localparam int COORD_MIN     = -(1 << (spct_pkg::COORD_BITS - 1));
    localparam int COORD_MAX     = (1 << (spct_pkg::COORD_BITS - 1)) - 1;
    localparam int SETTLE_CYCLES = 32;
    localparam int HOLD_CYCLES   = 400;
    localparam int PHASES        = 9;
    localparam int PHASE_ITEMS   = 140;
    localparam int QUEUE_LIMIT   = 8;

    typedef struct packed {
        spct_pkg::coord_t x;
        spct_pkg::coord_t y;
        logic             last;
    } vertex_beat_t;

    // clock, reset and dut ports
    logic               clk         = 1'b0;
    logic               rst_n       = 1'b0;
    logic               cfg_valid   = 1'b0;
    logic               cfg_ready;
    spct_pkg::cfg_reg_t cfg_index   = spct_pkg::CFG_START_X;
    spct_pkg::coord_t   cfg_data    = '0;
    logic               in_valid    = 1'b0;
    logic               in_stall;
    spct_pkg::coord_t   vertex_x    = '0;
    spct_pkg::coord_t   vertex_y    = '0;
    logic               last_vertex = 1'b0;
    logic               out_valid;
    logic               out_stall   = 1'b0;
    logic               crosses;

    // segment registers as the predictor sees them
    spct_pkg::coord_t seg_sx = '0;
    spct_pkg::coord_t seg_sy = '0;
    spct_pkg::coord_t seg_ex = '0;
    spct_pkg::coord_t seg_ey = '0;

    // ring state of the predictor
    spct_pkg::coord_t ring_first_x = '0;
    spct_pkg::coord_t ring_first_y = '0;
    spct_pkg::coord_t ring_prev_x  = '0;
    spct_pkg::coord_t ring_prev_y  = '0;
    bit               ring_open    = 1'b0;
    bit               ring_hit     = 1'b0;

    // pending vertex beats and expected crossing flags
    vertex_beat_t vertex_q[$];
    bit           crossing_q[$];

    int           fail_count = 0;
    bit           idle_on    = 1'b1;
    bit           hold_start = 1'b0;
    logic         recv_hold  = 1'b0;
    int           send_gap   = 0;
    int           recv_gap   = 0;
    bit           stall_next;
    bit           expected_crosses;
    vertex_beat_t next_beat;

    always #5 clk = ~clk;

    segment_polygon_crossing_test dut (.*);

    // exact test of edge a-b against the current segment
    function automatic bit edge_crosses_segment(input spct_pkg::coord_t ax,
                                                input spct_pkg::coord_t ay,
                                                input spct_pkg::coord_t bx,
                                                input spct_pkg::coord_t by);
        longint sx, sy, ex, ey, min_x, max_x, min_y, max_y;
        longint dx1, dy1, dx2, dy2, den, num;
        sx = seg_sx;
        sy = seg_sy;
        ex = seg_ex;
        ey = seg_ey;
        min_x = (sx < ex) ? sx : ex;
        max_x = (sx < ex) ? ex : sx;
        min_y = (sy < ey) ? sy : ey;
        max_y = (sy < ey) ? ey : sy;
        // bounding box rejection
        if (ax <= min_x && bx <= min_x) return 1'b0;
        if (ax >= max_x && bx >= max_x) return 1'b0;
        if (ay <= min_y && by <= min_y) return 1'b0;
        if (ay >= max_y && by >= max_y) return 1'b0;
        dx1 = ex - sx;
        dy1 = ey - sy;
        dx2 = longint'(bx) - longint'(ax);
        dy2 = longint'(by) - longint'(ay);
        den = dx1 * dy2 - dy1 * dx2;
        if (den == 0) return 1'b0;
        num = (ax - sx) * dy2 - (ay - sy) * dx2;
        if (den < 0)
        begin
            den = -den;
            num = -num;
        end
        return (num > 0) && (num < den);
    endfunction

    // advance the ring state by one accepted vertex
    function automatic void track_vertex(input spct_pkg::coord_t vx,
                                         input spct_pkg::coord_t vy, input logic last);
        if (!ring_open)
        begin
            ring_first_x = vx;
            ring_first_y = vy;
            ring_open    = 1'b1;
        end
        else if (edge_crosses_segment(ring_prev_x, ring_prev_y, vx, vy))
        begin
            ring_hit = 1'b1;
        end
        ring_prev_x = vx;
        ring_prev_y = vy;
        if (last)
        begin
            if (edge_crosses_segment(vx, vy, ring_first_x, ring_first_y))
                ring_hit = 1'b1;
            crossing_q.insert(crossing_q.size(), ring_hit);
            ring_first_x = '0;
            ring_first_y = '0;
            ring_prev_x  = '0;
            ring_prev_y  = '0;
            ring_open    = 1'b0;
            ring_hit     = 1'b0;
        end
    endfunction

    // vertex driver, fed from vertex_q
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                track_vertex(vertex_x, vertex_y, last_vertex);
            if (!in_valid || !in_stall)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (idle_on && $urandom_range(0, 7) == 0)
                begin
                    send_gap = $urandom_range(0, 16);
                    in_valid <= 1'b0;
                end
                else if (vertex_q.size() > 0)
                begin
                    next_beat = vertex_q.pop_front();
                    in_valid    <= 1'b1;
                    vertex_x    <= next_beat.x;
                    vertex_y    <= next_beat.y;
                    last_vertex <= next_beat.last;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and output stall
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (crossing_q.size() == 0)
                begin
                    $error("crosses beat with no result expected, got %0d", crosses);
                    fail_count++;
                end
                else
                begin
                    expected_crosses = crossing_q.pop_front();
                    if (crosses !== expected_crosses)
                    begin
                        $error("crosses mismatch: expected %0d, got %0d",
                               expected_crosses, crosses);
                        fail_count++;
                    end
                end
            end
            if (recv_gap > 0)
            begin
                recv_gap--;
                stall_next = 1'b1;
            end
            else if (idle_on && $urandom_range(0, 11) == 0)
            begin
                recv_gap   = $urandom_range(0, 16);
                stall_next = 1'b1;
            end
            else
            begin
                stall_next = 1'b0;
            end
            out_stall <= stall_next || recv_hold;
        end
    end

    // long receiver hold so that the block backs up into its input
    initial
    begin : receiver_hold
        wait (hold_start);
        @(posedge clk);
        recv_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        recv_hold <= 1'b0;
    end

    initial
    begin : watchdog
        #5000000;
        $display("segment_polygon_crossing_test verification failed");
        $finish;
    end

    function automatic int clamp_coord(input int v);
        return (v < COORD_MIN) ? COORD_MIN : ((v > COORD_MAX) ? COORD_MAX : v);
    endfunction

    function automatic int rand_between(input int lo, input int hi);
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    // coordinate mostly around the range lo..hi, often on its edges
    function automatic int pick_coord(input int lo, input int hi);
        int margin;
        int roll;
        margin = (hi - lo) / 2 + 16;
        roll   = $urandom_range(0, 99);
        if (roll < 60)
            return clamp_coord(rand_between(lo - margin, hi + margin));
        if (roll < 85)
        begin
            case ($urandom_range(0, 4))
                0:       return lo;
                1:       return hi;
                2:       return clamp_coord(lo - 1);
                3:       return clamp_coord(hi + 1);
                default: return clamp_coord((lo + hi) / 2);
            endcase
        end
        return rand_between(COORD_MIN, COORD_MAX);
    endfunction

    task automatic push_vertex(input int x, input int y, input logic last);
        vertex_beat_t beat;
        beat = '{spct_pkg::coord_t'(x), spct_pkg::coord_t'(y), last};
        vertex_q.insert(vertex_q.size(), beat);
    endtask

    // queue one random ring, return its vertex count
    function automatic int push_random_ring();
        int len;
        int lo_x, hi_x, lo_y, hi_y;
        vertex_beat_t beat;
        lo_x = (seg_sx < seg_ex) ? int'(seg_sx) : int'(seg_ex);
        hi_x = (seg_sx < seg_ex) ? int'(seg_ex) : int'(seg_sx);
        lo_y = (seg_sy < seg_ey) ? int'(seg_sy) : int'(seg_ey);
        hi_y = (seg_sy < seg_ey) ? int'(seg_ey) : int'(seg_sy);
        len  = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 14) : $urandom_range(1, 6);
        for (int i = 0; i < len; i++)
        begin
            beat = '{spct_pkg::coord_t'(pick_coord(lo_x, hi_x)),
                     spct_pkg::coord_t'(pick_coord(lo_y, hi_y)), i == len - 1};
            vertex_q.insert(vertex_q.size(), beat);
        end
        return len;
    endfunction

    // wait until every beat is in and every result out, then let the block settle
    task automatic wait_drained();
        do @(negedge clk);
        while (vertex_q.size() != 0 || in_valid || crossing_q.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input spct_pkg::cfg_reg_t idx, input int value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= spct_pkg::coord_t'(value);
        do @(posedge clk);
        while (!cfg_ready);
        case (idx)
            spct_pkg::CFG_START_X: seg_sx = spct_pkg::coord_t'(value);
            spct_pkg::CFG_START_Y: seg_sy = spct_pkg::coord_t'(value);
            spct_pkg::CFG_END_X:   seg_ex = spct_pkg::coord_t'(value);
            spct_pkg::CFG_END_Y:   seg_ey = spct_pkg::coord_t'(value);
            default:               ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    task automatic write_segment(input int sx, input int sy, input int ex, input int ey);
        write_reg(spct_pkg::CFG_START_X, sx);
        write_reg(spct_pkg::CFG_START_Y, sy);
        write_reg(spct_pkg::CFG_END_X, ex);
        write_reg(spct_pkg::CFG_END_Y, ey);
    endtask

    initial
    begin : stimulus
        int sent;
        int sx, sy, ex, ey, center_x, center_y;
        bit paused;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // reset segment is a single point: nothing crosses
        push_vertex(0, 0, 1'b1);
        push_vertex(5, 5, 1'b0);
        push_vertex(-5, -5, 1'b0);
        push_vertex(5, -5, 1'b1);
        wait_drained();

        // diagonal segment: plain crossing, hits on the end and start, parallel edge
        write_segment(-100, -100, 100, 100);
        push_vertex(-50, 50, 1'b0);
        push_vertex(50, -50, 1'b0);
        push_vertex(50, 50, 1'b1);
        push_vertex(90, 110, 1'b0);
        push_vertex(110, 90, 1'b0);
        push_vertex(200, 200, 1'b1);
        push_vertex(-110, -90, 1'b0);
        push_vertex(-90, -110, 1'b1);
        push_vertex(-50, -40, 1'b0);
        push_vertex(50, 60, 1'b1);
        wait_drained();

        // field extremes
        write_segment(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);
        push_vertex(COORD_MIN, COORD_MAX, 1'b0);
        push_vertex(COORD_MAX, COORD_MIN, 1'b0);
        push_vertex(COORD_MAX, COORD_MAX, 1'b1);

        // segment rewritten in the middle of a ring, to a vertical one
        push_vertex(COORD_MIN, COORD_MAX, 1'b0);
        wait_drained();
        write_segment(0, COORD_MIN, 0, COORD_MAX);
        push_vertex(COORD_MAX, COORD_MIN, 1'b1);
        wait_drained();

        // random rings, one segment per phase
        for (int phase = 0; phase < PHASES; phase++)
        begin
            sx = rand_between(COORD_MIN, COORD_MAX);
            sy = rand_between(COORD_MIN, COORD_MAX);
            ex = rand_between(COORD_MIN, COORD_MAX);
            ey = rand_between(COORD_MIN, COORD_MAX);
            center_x = rand_between(COORD_MIN, COORD_MAX);
            center_y = rand_between(COORD_MIN, COORD_MAX);
            case (phase)
                0:
                begin
                    sx = COORD_MAX;
                    sy = COORD_MIN;
                    ex = COORD_MIN;
                    ey = COORD_MAX;
                end
                1: ex = sx;
                2: ey = sy;
                3:
                begin
                    ex = sx;
                    ey = sy;
                end
                4, 5, 6:
                begin
                    sx = clamp_coord(center_x + rand_between(-300, 300));
                    sy = clamp_coord(center_y + rand_between(-300, 300));
                    ex = clamp_coord(center_x + rand_between(-300, 300));
                    ey = clamp_coord(center_y + rand_between(-300, 300));
                end
                default: ;
            endcase
            write_segment(sx, sy, ex, ey);
            if (phase == 4)
                hold_start = 1'b1;
            if (phase == PHASES - 1)
                idle_on = 1'b0;
            sent   = 0;
            paused = 1'b0;
            while (sent < PHASE_ITEMS)
            begin
                while (vertex_q.size() > QUEUE_LIMIT) @(negedge clk);
                sent += push_random_ring();
                // sender stops until all results are out
                if (phase == 6 && !paused && sent >= PHASE_ITEMS / 2)
                begin
                    wait_drained();
                    paused = 1'b1;
                end
            end
            wait_drained();
        end

        if (fail_count == 0)
            $display("segment_polygon_crossing_test verification clean");
        else
            $display("segment_polygon_crossing_test verification failed");
        $finish;
    end

endmodule

[files.f]
+incdir+hdl
hdl/spct_pkg.sv
hdl/segment_polygon_crossing_test.sv
hdl/spct_checker.sv
sim/tb.sv
